// ===== sv/fwm_pkg.sv =====
// ----------------------------------------------------------------------------
// fwm_pkg: shared types and constants of the frame window multiplier
// Configuration layout, controller commands, window constants in Q1.15 and
// the elaboration-time builder for the quarter-wave cosine table.
// ----------------------------------------------------------------------------
`default_nettype none

package fwm_pkg;

  // Default parameter values.
  localparam int SampleBitsDef      = 16;
  localparam int PhaseBitsDef       = 24;
  localparam int CosTableBitsDef    = 10;
  localparam int MaxWindowLengthDef = 4096;

  // Configuration port.
  localparam int CfgIdxBits  = 2;
  localparam int CfgDataBits = 24;
  localparam int ModeBits    = 2;
  localparam int LengthBits  = 13;
  localparam int StepBits    = 24;

  localparam logic [CfgIdxBits-1:0] CfgIdxMode   = 2'd0;
  localparam logic [CfgIdxBits-1:0] CfgIdxLength = 2'd1;
  localparam logic [CfgIdxBits-1:0] CfgIdxStep   = 2'd2;

  localparam logic [ModeBits-1:0] ModeHann     = 2'd0;
  localparam logic [ModeBits-1:0] ModeHamming  = 2'd1;
  localparam logic [ModeBits-1:0] ModeBlackman = 2'd2;

  localparam logic [ModeBits-1:0]   ModeReset   = ModeHann;
  localparam logic [LengthBits-1:0] LengthReset = 13'd1024;
  localparam logic [StepBits-1:0]   StepReset   = 24'd16400;

  // Cosine table entries are unsigned Q1.15, 1.0 is 32768.
  localparam int                CosBits   = 16;
  localparam logic [CosBits-1:0] CosOne    = 16'd32768;
  localparam int                RoundQ15  = 16384;

  typedef struct packed {
    logic [ModeBits-1:0]   mode;
    logic [LengthBits-1:0] length;
    logic [StepBits-1:0]   step;
  } fwm_cfg_t;

  // One step of the datapath sequence per flag.
  typedef struct packed {
    logic capture;   // take the sample and the current phase, advance the phase
    logic wrap;      // this sample ends the frame: phase returns to zero
    logic sel_dbl;   // address the cosine table with the doubled phase
    logic ld_c1;     // latch the first cosine
    logic mac1;      // constant term minus the first cosine term
    logic mac2;      // add the second cosine term
    logic coef;      // round and clamp the coefficient
    logic mul;       // sample times coefficient
    logic out_load;  // round, saturate and load the output register
    logic last;      // frame end flag for the result
  } fwm_cmd_t;

  typedef struct packed {
    logic [14:0] a;
    logic [14:0] b;
    logic [14:0] c;
  } fwm_coefs_t;

  // Window w = a - b*cos(x) + c*cos(2x), constants in Q1.15.
  function automatic fwm_coefs_t mode_coefs(logic [ModeBits-1:0] mode);
    fwm_coefs_t k;
    case (mode)
      ModeHamming: begin
        k.a = 15'd17695;
        k.b = 15'd15073;
        k.c = 15'd0;
      end
      ModeBlackman: begin
        k.a = 15'd13763;
        k.b = 15'd16384;
        k.c = 15'd2621;
      end
      default: begin
        k.a = 15'd16384;
        k.b = 15'd16384;
        k.c = 15'd0;
      end
    endcase
    return k;
  endfunction

  localparam longint unsigned HalfPiQ30 = 64'd1686629713;

  // Floor of n over the divisor (2j-1)*2j of Taylor step j, for n below 2^32.
  // The reciprocal floor(2^32/d) underestimates by at most one, so a single
  // compare and add finishes the quotient.
  function automatic longint unsigned taylor_quot(longint unsigned n, int j);
    longint unsigned d;
    longint unsigned m;
    longint unsigned q;
    case (j)
      1:       begin d = 64'd2;   m = 64'd2147483648; end
      2:       begin d = 64'd12;  m = 64'd357913941;  end
      3:       begin d = 64'd30;  m = 64'd143165576;  end
      4:       begin d = 64'd56;  m = 64'd76695844;   end
      5:       begin d = 64'd90;  m = 64'd47721858;   end
      6:       begin d = 64'd132; m = 64'd32537631;   end
      7:       begin d = 64'd182; m = 64'd23598721;   end
      8:       begin d = 64'd240; m = 64'd17895697;   end
      9:       begin d = 64'd306; m = 64'd14035840;   end
      default: begin d = 64'd380; m = 64'd11302545;   end
    endcase
    q = (n * m) >> 32;
    if (n - q * d >= d) begin
      q = q + 64'd1;
    end
    return q;
  endfunction

  // Entry k of the quarter-wave table: cosine of pi/2 * k / 2^table_bits by an
  // eleven-term Taylor series in Q30, rounded half up to Q1.15. Used only to
  // build constants at elaboration.
  function automatic logic [CosBits-1:0] cos_rom_entry(int k, int table_bits);
    longint unsigned half;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    longint          v;
    half = (64'd1 << table_bits) >> 1;
    x    = (HalfPiQ30 * longint'(k) + half) >> table_bits;
    x2   = (x * x) >> 30;
    term = 64'd1 << 30;
    sum  = longint'(term);
    for (int j = 1; j <= 10; j++) begin
      term    = (term * x2) >> 30;
      term    = taylor_quot(term, j);
      if (j % 2 == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    v = (sum + 16384) >>> 15;
    if (v > 32768) begin
      v = 32768;
    end
    return CosBits'(v);
  endfunction

endpackage

`default_nettype wire

// ===== sv/fwm_if.sv =====
// ----------------------------------------------------------------------------
// fwm_if: channel interfaces of the frame window multiplier
// Configuration write channel, input sample channel and result channel, each
// a valid/ready channel with a source and a sink side.
// ----------------------------------------------------------------------------
`default_nettype none

interface fwm_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [fwm_pkg::CfgIdxBits-1:0]    index;
  logic [fwm_pkg::CfgDataBits-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

interface fwm_in_if #(
  parameter int SAMPLE_BITS = fwm_pkg::SampleBitsDef
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

interface fwm_out_if #(
  parameter int SAMPLE_BITS = fwm_pkg::SampleBitsDef
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;
  logic                          frame_last;

  modport source (output valid, output sample_out, output frame_last, input ready);
  modport sink   (input valid, input sample_out, input frame_last, output ready);
endinterface

`default_nettype wire

// ===== sv/fwm_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// fwm_cfg_regs: configuration registers
// Window mode, frame length and phase step, written through the configuration
// channel; values are masked to the register width.
// ----------------------------------------------------------------------------
`default_nettype none

module fwm_cfg_regs (
  input  logic              clk_i,
  input  logic              rst_ni,
  fwm_cfg_if.sink           cfg_i,
  output fwm_pkg::fwm_cfg_t cfg_o
);
  import fwm_pkg::*;

  fwm_cfg_t cfg_q;

  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode   <= ModeReset;
      cfg_q.length <= LengthReset;
      cfg_q.step   <= StepReset;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CfgIdxMode:   cfg_q.mode   <= cfg_i.data[ModeBits-1:0];
        CfgIdxLength: cfg_q.length <= cfg_i.data[LengthBits-1:0];
        CfgIdxStep:   cfg_q.step   <= cfg_i.data[StepBits-1:0];
        default:      cfg_q        <= cfg_q;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== sv/fwm_ctrl.sv =====
// ----------------------------------------------------------------------------
// fwm_ctrl: sequencing controller
// Steps each sample through the datapath, keeps the sample index of the
// frame, decides the frame end and owns the result valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module fwm_ctrl #(
  parameter int MAX_WINDOW_LENGTH = fwm_pkg::MaxWindowLengthDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  fwm_pkg::fwm_cfg_t cfg_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output fwm_pkg::fwm_cmd_t cmd_o
);
  import fwm_pkg::*;

  localparam int IdxBits  = $clog2(MAX_WINDOW_LENGTH);
  localparam int LenWide  = $clog2(MAX_WINDOW_LENGTH + 1);
  localparam int LenBits  = (LenWide > LengthBits) ? LenWide : LengthBits;
  localparam logic [LenBits-1:0] MaxLen = LenBits'(MAX_WINDOW_LENGTH);
  localparam logic [LenBits-1:0] MinLen = LenBits'(2);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD1,
    ST_RD2,
    ST_MAC1,
    ST_MAC2,
    ST_COEF,
    ST_MUL,
    ST_DONE
  } state_e;

  state_e               state_q;
  logic [IdxBits-1:0]   idx_q;
  logic                 last_q;
  logic                 out_valid_q;

  logic [LenBits-1:0]   len_ext;
  logic [LenBits-1:0]   len_eff;
  logic                 is_last;
  logic                 in_beat;
  logic                 out_free;

  always_comb begin
    len_ext = LenBits'(cfg_i.length);
    if (len_ext < MinLen) begin
      len_eff = MinLen;
    end else if (len_ext > MaxLen) begin
      len_eff = MaxLen;
    end else begin
      len_eff = len_ext;
    end
  end

  // An index at or past the end also closes the frame (length lowered mid-frame).
  assign is_last  = LenBits'(idx_q) >= (len_eff - LenBits'(1));
  assign in_beat  = in_valid_i && (state_q == ST_IDLE);
  assign out_free = !out_valid_q || out_ready_i;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o          = '0;
    cmd_o.capture  = in_beat;
    cmd_o.wrap     = is_last;
    cmd_o.sel_dbl  = (state_q == ST_RD2);
    cmd_o.ld_c1    = (state_q == ST_RD2);
    cmd_o.mac1     = (state_q == ST_MAC1);
    cmd_o.mac2     = (state_q == ST_MAC2);
    cmd_o.coef     = (state_q == ST_COEF);
    cmd_o.mul      = (state_q == ST_MUL);
    cmd_o.out_load = (state_q == ST_DONE) && out_free;
    cmd_o.last     = last_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if ((state_q == ST_DONE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_beat) begin
            last_q  <= is_last;
            idx_q   <= is_last ? '0 : idx_q + IdxBits'(1);
            state_q <= ST_RD1;
          end
        end
        ST_RD1:  state_q <= ST_RD2;
        ST_RD2:  state_q <= ST_MAC1;
        ST_MAC1: state_q <= ST_MAC2;
        ST_MAC2: state_q <= ST_COEF;
        ST_COEF: state_q <= ST_MUL;
        ST_MUL:  state_q <= ST_DONE;
        ST_DONE: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== sv/fwm_dp.sv =====
// ----------------------------------------------------------------------------
// fwm_dp: window datapath
// Phase accumulator, quarter-wave cosine table with registered read,
// coefficient accumulator, sample multiplier and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module fwm_dp #(
  parameter int SAMPLE_BITS    = fwm_pkg::SampleBitsDef,
  parameter int PHASE_BITS     = fwm_pkg::PhaseBitsDef,
  parameter int COS_TABLE_BITS = fwm_pkg::CosTableBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  fwm_pkg::fwm_cfg_t             cfg_i,
  input  fwm_pkg::fwm_cmd_t             cmd_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  output logic signed [SAMPLE_BITS-1:0] sample_o,
  output logic                          last_o
);
  import fwm_pkg::*;

  localparam int RomSize   = (1 << COS_TABLE_BITS) + 1;
  localparam int AddrBits  = COS_TABLE_BITS + 1;
  localparam int FracBits  = PHASE_BITS - 2;
  localparam int Shift     = PHASE_BITS - 2 - COS_TABLE_BITS;
  localparam int WBits     = 33;
  localparam int ProdBits  = SAMPLE_BITS + CosBits + 1;
  localparam int RBits     = SAMPLE_BITS + 2;

  localparam logic [AddrBits-1:0] RomLast   = AddrBits'(1 << COS_TABLE_BITS);
  localparam logic [FracBits:0]   RoundHalf = (FracBits + 1)'((64'd1 << Shift) >> 1);
  localparam logic signed [RBits-1:0] RMax  =
    RBits'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [RBits-1:0] RMin  = -RMax - RBits'(1);

  // Quarter-wave cosine table, built from constants at elaboration.
  logic [CosBits-1:0] cos_rom [RomSize];
  for (genvar k = 0; k < RomSize; k++) begin : g_rom
    localparam logic [CosBits-1:0] Entry = cos_rom_entry(k, COS_TABLE_BITS);
    assign cos_rom[k] = Entry;
  end

  logic [PHASE_BITS-1:0]         phase_acc_q;
  logic [PHASE_BITS-1:0]         ph_q;
  logic signed [SAMPLE_BITS-1:0] x_q;
  logic [CosBits-1:0]            rom_q;
  logic                          neg_q;
  logic signed [CosBits:0]       c1_q;
  logic signed [CosBits:0]       c2_q;
  logic signed [WBits-1:0]       w_q;
  logic [CosBits-1:0]            coef_q;
  logic signed [ProdBits-1:0]    prod_q;
  logic signed [SAMPLE_BITS-1:0] sample_out_q;
  logic                          last_q;

  logic [PHASE_BITS-1:0]         look_ph;
  logic [FracBits:0]             frac_sum;
  logic [AddrBits-1:0]           a_idx;
  logic [AddrBits-1:0]           rom_addr;
  logic                          rom_neg;
  logic signed [CosBits:0]       rom_signed;
  fwm_coefs_t                    coefs;
  logic signed [WBits-1:0]       a_term;
  logic signed [WBits-1:0]       b_prod;
  logic signed [WBits-1:0]       c_prod;
  logic signed [WBits-1:0]       rnd_w;
  logic [CosBits-1:0]            coef_d;
  logic signed [ProdBits-1:0]    prod_d;
  logic signed [ProdBits-1:0]    rnd_p;
  logic signed [RBits-1:0]       r_val;
  logic signed [SAMPLE_BITS-1:0] sat_d;

  // Table lookup: the top two phase bits pick the quadrant; the rest are
  // rounded to the table resolution. Odd quadrants read the mirrored entry.
  assign look_ph  = cmd_i.sel_dbl ? {ph_q[PHASE_BITS-2:0], 1'b0} : ph_q;
  assign frac_sum = {1'b0, look_ph[FracBits-1:0]} + RoundHalf;
  assign a_idx    = frac_sum[FracBits:Shift];
  assign rom_addr = look_ph[PHASE_BITS-2] ? (RomLast - a_idx) : a_idx;
  assign rom_neg  = look_ph[PHASE_BITS-1] ^ look_ph[PHASE_BITS-2];

  assign rom_signed = neg_q ? -$signed({1'b0, rom_q}) : $signed({1'b0, rom_q});

  assign coefs  = mode_coefs(cfg_i.mode);
  assign a_term = $signed({3'b000, coefs.a, 15'd0});
  assign b_prod = WBits'($signed({1'b0, coefs.b})) * WBits'(c1_q);
  assign c_prod = WBits'($signed({1'b0, coefs.c})) * WBits'(c2_q);
  assign rnd_w  = w_q + WBits'(RoundQ15);

  always_comb begin
    if (w_q[WBits-1]) begin
      coef_d = '0;
    end else if (rnd_w[WBits-1:15] > (WBits - 15)'(CosOne)) begin
      coef_d = CosOne;
    end else begin
      coef_d = rnd_w[30:15];
    end
  end

  assign prod_d = ProdBits'(x_q) * ProdBits'($signed({1'b0, coef_q}));

  // Adding half and shifting arithmetically rounds ties toward plus infinity.
  assign rnd_p = prod_q + ProdBits'(RoundQ15);
  assign r_val = $signed(rnd_p[ProdBits-1:15]);

  always_comb begin
    if (r_val > RMax) begin
      sat_d = RMax[SAMPLE_BITS-1:0];
    end else if (r_val < RMin) begin
      sat_d = RMin[SAMPLE_BITS-1:0];
    end else begin
      sat_d = r_val[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_acc_q <= '0;
    end else if (cmd_i.capture) begin
      phase_acc_q <= cmd_i.wrap ? '0 : phase_acc_q + PHASE_BITS'(cfg_i.step);
    end
  end

  always_ff @(posedge clk_i) begin
    rom_q <= cos_rom[rom_addr];
    neg_q <= rom_neg;
    if (cmd_i.capture) begin
      x_q  <= sample_i;
      ph_q <= phase_acc_q;
    end
    if (cmd_i.ld_c1) begin
      c1_q <= rom_signed;
    end
    if (cmd_i.mac1) begin
      c2_q <= rom_signed;
      w_q  <= a_term - b_prod;
    end
    if (cmd_i.mac2) begin
      w_q <= w_q + c_prod;
    end
    if (cmd_i.coef) begin
      coef_q <= coef_d;
    end
    if (cmd_i.mul) begin
      prod_q <= prod_d;
    end
    if (cmd_i.out_load) begin
      sample_out_q <= sat_d;
      last_q       <= cmd_i.last;
    end
  end

  assign sample_o = sample_out_q;
  assign last_o   = last_q;

endmodule

`default_nettype wire

// ===== sv/frame_window_multiplier_core.sv =====
// ----------------------------------------------------------------------------
// frame_window_multiplier_core: Hann, Hamming and Blackman frame window
// Multiplies each Q1.15 sample by the window coefficient of its place in
// the frame and marks the last sample of every frame.
// ----------------------------------------------------------------------------
// Each sample is taken and run through the whole sequence before the next
// is accepted: taking the beat, two reads of the single registered cosine
// table port (phase and doubled phase), two coefficient accumulate steps,
// rounding the coefficient, the sample multiply and loading the result
// register. The result register lets the next sample be taken while
// a result still waits; if it is still full when the next result is ready,
// the sequence holds until it drains. The phase step must be written as
// round(2^24 / (n - 1)) for a frame length n; configuration writes are taken
// in any cycle and do not disturb the frame position.
`default_nettype none

module frame_window_multiplier_core #(
  parameter int SAMPLE_BITS       = fwm_pkg::SampleBitsDef,
  parameter int PHASE_BITS        = fwm_pkg::PhaseBitsDef,
  parameter int COS_TABLE_BITS    = fwm_pkg::CosTableBitsDef,
  parameter int MAX_WINDOW_LENGTH = fwm_pkg::MaxWindowLengthDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  fwm_cfg_if.sink  cfg_i,
  fwm_in_if.sink   samp_i,
  fwm_out_if.source samp_o
);
  import fwm_pkg::*;

  fwm_cfg_t cfg;
  fwm_cmd_t cmd;
  logic     in_ready;
  logic     out_valid;

  fwm_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  fwm_ctrl #(
    .MAX_WINDOW_LENGTH (MAX_WINDOW_LENGTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (samp_i.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (samp_o.ready),
    .cmd_o       (cmd)
  );

  fwm_dp #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .PHASE_BITS     (PHASE_BITS),
    .COS_TABLE_BITS (COS_TABLE_BITS)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .cmd_i    (cmd),
    .sample_i (samp_i.sample_in),
    .sample_o (samp_o.sample_out),
    .last_o   (samp_o.frame_last)
  );

  assign samp_i.ready = in_ready;
  assign samp_o.valid = out_valid;

  // One sample is in flight at a time: no beat is taken right after another.
  a_no_back_to_back : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (samp_i.valid && samp_i.ready) |=> !samp_i.ready)
    else $error("input beat taken while a sample is still in the datapath");

  // A result is never loaded over one that has not been delivered.
  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!samp_o.valid || samp_o.ready))
    else $error("result register overwritten before its beat completed");

  // The datapath runs at most one step of the sequence per cycle.
  a_one_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.capture, cmd.ld_c1, cmd.mac1, cmd.mac2, cmd.coef, cmd.mul,
              cmd.out_load}))
    else $error("more than one datapath step commanded in a cycle");

  // A loaded result is offered in the next cycle.
  a_load_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |=> samp_o.valid)
    else $error("loaded result not offered on the output");

endmodule

`default_nettype wire
